[rtl/core/mfd_pkg.sv]
// Shared types and constants of the multi-tap fractional delay line.
`default_nettype none
package mfd_pkg;

  // Field widths fixed by the item formats.
  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 8;
  localparam int DELAY_W  = 24;
  localparam int ALPHA_W  = 25;
  localparam int TAP_W    = 4;
  localparam int DIST_W   = 17;
  localparam int SD_W     = 32;

  // Ring buffer geometry.
  localparam int ADDR_W       = 16;
  localparam int BUFFER_DEPTH = 1 << ADDR_W;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXD  = 1'b1;
  localparam int CFG_W = ALPHA_W;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 25'h1000000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 25'd2330;
  localparam logic [DELAY_W-1:0] MAXD_RESET  = 24'hFFFF00;

  // Smoothed tap delay after reset: 24000 samples in Q16.16.
  localparam logic [SD_W-1:0] SD_RESET = 32'h5DC00000;

  // Shared multiplier geometry and the reciprocal of three in Q0.33.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic signed [MUL_W-1:0] RECIP3 = 33'sh0AAAAAAAB;

  // Interpolation position unit: two stored fractions summed.
  localparam int X_W = FRAC_W + 1;
  localparam int XS_W = X_W + 3;

  // One cycle of requests to the ring memory.
  typedef struct packed {
    logic                you_we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } ring_req_t;

endpackage
`default_nettype wire

[rtl/core/mfd_if.sv]
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface mfd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [mfd_pkg::SAMPLE_W-1:0]    in_sample;
  logic        [mfd_pkg::DELAY_W-1:0]     delay_request;
  logic        [mfd_pkg::TAP_W-1:0]       tap_index;
  logic                                   write_enable;
  logic                                   reverse_mode;

  modport source (output valid, operation, in_sample, delay_request, tap_index,
                  write_enable, reverse_mode, input ready);
  modport sink (input valid, operation, in_sample, delay_request, tap_index,
                write_enable, reverse_mode, output ready);
endinterface

interface mfd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mfd_pkg::SAMPLE_W-1:0]    out_sample;
  logic        [mfd_pkg::DIST_W-1:0]      reverse_distance;

  modport source (output valid, out_sample, reverse_distance, input ready);
  modport sink (input valid, out_sample, reverse_distance, output ready);
endinterface
`default_nettype wire

[rtl/core/mfd_ring.sv]
// Ring sample memory with one write port, one registered read port and a clear sweep.
`default_nettype none
module mfd_ring (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mfd_pkg::ring_req_t            req_i,
  output logic [mfd_pkg::SAMPLE_W-1:0]       rdata_o,
  output logic                               busy_o
);

  logic [mfd_pkg::SAMPLE_W-1:0] mem [mfd_pkg::BUFFER_DEPTH];
  logic [mfd_pkg::SAMPLE_W-1:0] rdata_q;
  logic [mfd_pkg::ADDR_W-1:0]   clr_addr_q;
  logic                         clr_busy_q;

  // Clear sweep after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {mfd_pkg::ADDR_W{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Memory array: the sweep owns the write port until it finishes.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.you_we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule
`default_nettype wire

[rtl/core/mfd_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module mfd_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [mfd_pkg::MUL_W-1:0]  a_i,
  input  wire logic signed [mfd_pkg::MUL_W-1:0]  b_i,
  output logic signed [mfd_pkg::PROD_W-1:0]      prod_o
);

  logic signed [mfd_pkg::PROD_W-1:0] prod_q;

  // One product per cycle, ready the cycle after its operands.
  always_ff @(posedge clk_i) begin
    prod_q <= mfd_pkg::PROD_W'(a_i) * mfd_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[rtl/core/multitap_fractional_delay.sv]
// Top level of the multi-tap fractional delay line with cubic interpolation.
//
//   channel   direction  beat contents
//   in_i      sink       operation, in_sample, delay_request, tap_index,
//                        write_enable, reverse_mode
//   out_o     source     out_sample, reverse_distance
//   cfg_*     write      index 0 smoothing_alpha, index 1 max_delay
//
// A simple read passes from acceptance through states SIM, WR, TGT, RD and
// DAT to the result register; a smoothed read passes SMA, SMB and SMO, then
// the cubic interpolation states that share the single multiplier. After reset
// all 65536 ring entries are swept to zero, during which no beat is accepted.
// The result sits in an output register; a stalled sink holds the sequencer in
// its final state and the next beat is taken in the cycle after the result register is loaded.
`default_nettype none
module multitap_fractional_delay #(
  parameter int TAP_COUNT = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  mfd_in_if.sink                                in_i,
  mfd_out_if.source                             out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [mfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mfd_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int TW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ACC_W = 50;
  localparam int COEF_W = 26;
  localparam int PQR_W = 21;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SMA  = 5'd1;
  localparam logic [4:0] ST_SMB  = 5'd2;
  localparam logic [4:0] ST_SMO  = 5'd3;
  localparam logic [4:0] ST_SIM  = 5'd4;
  localparam logic [4:0] ST_WR   = 5'd5;
  localparam logic [4:0] ST_TGT  = 5'd6;
  localparam logic [4:0] ST_RD   = 5'd7;
  localparam logic [4:0] ST_DAT  = 5'd8;
  localparam logic [4:0] ST_P    = 5'd9;
  localparam logic [4:0] ST_Q    = 5'd10;
  localparam logic [4:0] ST_R    = 5'd11;
  localparam logic [4:0] ST_N0   = 5'd12;
  localparam logic [4:0] ST_N3   = 5'd13;
  localparam logic [4:0] ST_N1   = 5'd14;
  localparam logic [4:0] ST_N2   = 5'd15;
  localparam logic [4:0] ST_D1   = 5'd16;
  localparam logic [4:0] ST_D3   = 5'd17;
  localparam logic [4:0] ST_M0   = 5'd18;
  localparam logic [4:0] ST_M1   = 5'd19;
  localparam logic [4:0] ST_M2   = 5'd20;
  localparam logic [4:0] ST_M3   = 5'd21;
  localparam logic [4:0] ST_SUM  = 5'd22;
  localparam logic [4:0] ST_OUT  = 5'd23;

  // Control state.
  logic [4:0]                     state_q, state_d;
  logic                           ov_q;
  logic [mfd_pkg::ADDR_W-1:0]     wi_q, rp_q;
  logic [mfd_pkg::DIST_W-1:0]     dist_q;
  logic [mfd_pkg::SD_W-1:0]       sd_q [TAP_COUNT];
  logic signed [mfd_pkg::SAMPLE_W-1:0] h_q [4];
  logic [mfd_pkg::FRAC_W-1:0]     f_q [4];
  logic [mfd_pkg::ALPHA_W-1:0]    alpha_q;
  logic [mfd_pkg::DELAY_W-1:0]    maxd_q;

  // Item payload and working registers.
  logic                           op_q, we_q, rev_q;
  logic signed [mfd_pkg::SAMPLE_W-1:0] smp_q;
  logic [mfd_pkg::DELAY_W-1:0]    req_q;
  logic [mfd_pkg::TAP_W-1:0]      tap_q;
  logic [mfd_pkg::ADDR_W-1:0]     dly_q, ptr_q;
  logic [mfd_pkg::FRAC_W-1:0]     fr_q;
  logic [mfd_pkg::X_W-1:0]        x_q;
  logic [56:0]                    acc1_q;
  logic signed [PQR_W-1:0]        p_q, q_q, r_q;
  logic signed [31:0]             n0_q, n1_q, n2_q, n3_q;
  logic signed [COEF_W-1:0]       c0_q, c1_q, c2_q, c3_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [mfd_pkg::SAMPLE_W-1:0] y_q, os_q;
  logic [mfd_pkg::DIST_W-1:0]     od_q;

  // Submodule connections.
  mfd_pkg::ring_req_t             ring_req;
  logic [mfd_pkg::SAMPLE_W-1:0]   ring_rdata;
  logic                           ring_busy;
  logic signed [mfd_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [mfd_pkg::PROD_W-1:0] prod;

  mfd_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .rdata_o (ring_rdata),
    .busy_o  (ring_busy)
  );

  mfd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Handshakes.
  logic in_fire, out_free;
  assign in_i.ready  = (state_q == ST_IDLE) && !ring_busy;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !ov_q || out_o.ready;
  assign out_o.valid = ov_q;
  assign out_o.out_sample = os_q;
  assign out_o.reverse_distance = od_q;

  // Smoothing arithmetic.
  logic [mfd_pkg::ALPHA_W-1:0] alpha_eff, beta;
  logic [TW-1:0]               tap_sel;
  logic [mfd_pkg::SD_W-1:0]    sd_sel;
  logic [56:0]                 sum_s;
  logic [31:0]                 avg;
  logic [32:0]                 t33, lim33, tc;
  logic [mfd_pkg::ADDR_W-1:0]  dly_sm;

  assign alpha_eff = (alpha_q > mfd_pkg::ALPHA_ONE) ? mfd_pkg::ALPHA_ONE : alpha_q;
  assign beta      = mfd_pkg::ALPHA_ONE - alpha_eff;
  assign tap_sel   = ({1'b0, tap_q} < 5'(TAP_COUNT)) ? tap_q[TW-1:0] : '0;
  assign sd_sel    = sd_q[tap_sel];
  assign sum_s     = acc1_q + prod[56:0] + 57'h800000;
  assign avg       = sum_s[55:24];
  assign t33       = {1'b0, avg} + 33'h10000;
  assign lim33     = {1'b0, maxd_q, 8'h00};
  assign tc        = (t33 > lim33) ? lim33 : t33;
  assign dly_sm    = tc[32] ? {mfd_pkg::ADDR_W{1'b1}} : tc[31:16];

  // Simple mode: clamp and round half to even.
  logic [mfd_pkg::DELAY_W-1:0] ts;
  logic [mfd_pkg::ADDR_W-1:0]  di, dly_si;
  logic                        inc;
  assign ts     = (req_q > maxd_q) ? maxd_q : req_q;
  assign di     = ts[23:8];
  assign inc    = (ts[7:0] > 8'd128) || ((ts[7:0] == 8'd128) && di[0]);
  assign dly_si = (inc && (di == {mfd_pkg::ADDR_W{1'b1}})) ? di : di + 16'(inc);

  // Read target and reverse pointer walk.
  logic [mfd_pkg::ADDR_W-1:0] tgt, rp1;
  logic                       jump;
  assign tgt  = dly_q + wi_q;
  assign rp1  = rp_q + 1'b1;
  assign jump = ((tgt > wi_q) && (rp1 > tgt)) ||
                ((tgt < wi_q) && (rp1 < wi_q) && (rp1 > tgt));

  // Interpolation position terms.
  logic signed [mfd_pkg::XS_W-1:0] xs, xmu, xpu, xm2u;
  localparam logic signed [mfd_pkg::XS_W-1:0] U_ONE =
    mfd_pkg::XS_W'(1 << (mfd_pkg::FRAC_W + 1));
  assign xs   = $signed({3'b000, x_q});
  assign xmu  = xs - U_ONE;
  assign xpu  = xs + U_ONE;
  assign xm2u = xs - (U_ONE <<< 1);

  // Rounded coefficient division by 16 and by 48 (16 then reciprocal of 3).
  logic [31:0] m0, m1, m2, m3;
  logic [27:0] v0, v3, g1, g2;
  assign m0 = n0_q[31] ? 32'(-n0_q) : 32'(n0_q);
  assign m1 = n1_q[31] ? 32'(-n1_q) : 32'(n1_q);
  assign m2 = n2_q[31] ? 32'(-n2_q) : 32'(n2_q);
  assign m3 = n3_q[31] ? 32'(-n3_q) : 32'(n3_q);
  assign v0 = 28'((m0 + 32'd24) >> 4);
  assign v3 = 28'((m3 + 32'd24) >> 4);
  assign g1 = 28'((m1 + 32'd8) >> 4);
  assign g2 = 28'((m2 + 32'd8) >> 4);

  logic [COEF_W-1:0] q3;
  assign q3 = prod[58:33];

  // Final rounding and saturation.
  logic signed [ACC_W-1:0] acc_f, acc_r;
  logic signed [25:0]      rnd;
  logic signed [mfd_pkg::SAMPLE_W-1:0] y_sat;
  assign acc_f = acc_q + prod[ACC_W-1:0];
  assign acc_r = acc_f + ACC_W'(1 << 23);
  assign rnd   = acc_r[ACC_W-1:24];
  assign y_sat = (rnd > 26'sd8388607) ? 24'sh7FFFFF :
                 (rnd < -26'sd8388608) ? 24'sh800000 : rnd[23:0];

  // Multiplier operand selection per state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SMA: begin
        mul_a = $signed({8'h00, alpha_eff});
        mul_b = $signed({1'b0, req_q, 8'h00});
      end
      ST_SMB: begin
        mul_a = $signed({8'h00, beta});
        mul_b = $signed({1'b0, sd_sel});
      end
      ST_P: begin
        mul_a = mfd_pkg::MUL_W'(xs);
        mul_b = mfd_pkg::MUL_W'(xmu);
      end
      ST_Q: begin
        mul_a = mfd_pkg::MUL_W'(xpu);
        mul_b = mfd_pkg::MUL_W'(xmu);
      end
      ST_R: begin
        mul_a = mfd_pkg::MUL_W'(xs);
        mul_b = mfd_pkg::MUL_W'(xpu);
      end
      ST_N0: begin
        mul_a = mfd_pkg::MUL_W'(p_q);
        mul_b = mfd_pkg::MUL_W'(xm2u);
      end
      ST_N3: begin
        mul_a = mfd_pkg::MUL_W'(p_q);
        mul_b = mfd_pkg::MUL_W'(xpu);
      end
      ST_N1: begin
        mul_a = mfd_pkg::MUL_W'(q_q);
        mul_b = mfd_pkg::MUL_W'(xm2u);
      end
      ST_N2: begin
        mul_a = mfd_pkg::MUL_W'(r_q);
        mul_b = mfd_pkg::MUL_W'(xm2u);
      end
      ST_D1: begin
        mul_a = $signed({5'b00000, v0});
        mul_b = mfd_pkg::RECIP3;
      end
      ST_D3: begin
        mul_a = $signed({5'b00000, v3});
        mul_b = mfd_pkg::RECIP3;
      end
      ST_M0: begin
        mul_a = mfd_pkg::MUL_W'(h_q[0]);
        mul_b = mfd_pkg::MUL_W'(c0_q);
      end
      ST_M1: begin
        mul_a = mfd_pkg::MUL_W'(h_q[1]);
        mul_b = mfd_pkg::MUL_W'(c1_q);
      end
      ST_M2: begin
        mul_a = mfd_pkg::MUL_W'(h_q[2]);
        mul_b = mfd_pkg::MUL_W'(c2_q);
      end
      ST_M3: begin
        mul_a = mfd_pkg::MUL_W'(h_q[3]);
        mul_b = mfd_pkg::MUL_W'(c3_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Ring memory requests.
  always_comb begin
    ring_req.you_we = (state_q == ST_WR) && we_q;
    ring_req.waddr  = wi_q;
    ring_req.wdata  = smp_q;
    ring_req.re     = (state_q == ST_RD);
    ring_req.raddr  = ptr_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = in_i.operation ? ST_SIM : ST_SMA;
        end
      end
      ST_SMA:  state_d = ST_SMB;
      ST_SMB:  state_d = ST_SMO;
      ST_SMO:  state_d = ST_WR;
      ST_SIM:  state_d = ST_WR;
      ST_WR:   state_d = ST_TGT;
      ST_TGT:  state_d = ST_RD;
      ST_RD:   state_d = ST_DAT;
      ST_DAT:  state_d = op_q ? ST_OUT : ST_P;
      ST_P:    state_d = ST_Q;
      ST_Q:    state_d = ST_R;
      ST_R:    state_d = ST_N0;
      ST_N0:   state_d = ST_N3;
      ST_N3:   state_d = ST_N1;
      ST_N1:   state_d = ST_N2;
      ST_N2:   state_d = ST_D1;
      ST_D1:   state_d = ST_D3;
      ST_D3:   state_d = ST_M0;
      ST_M0:   state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and the architectural state of the delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      wi_q    <= '0;
      rp_q    <= '0;
      dist_q  <= '0;
      alpha_q <= mfd_pkg::ALPHA_RESET;
      maxd_q  <= mfd_pkg::MAXD_RESET;
      for (int i = 0; i < TAP_COUNT; i++) begin
        sd_q[i] <= mfd_pkg::SD_RESET;
      end
      for (int i = 0; i < 4; i++) begin
        h_q[i] <= '0;
        f_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mfd_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
          mfd_pkg::CFG_MAXD:  maxd_q  <= cfg_data_i[mfd_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if ((state_q == ST_OUT) && out_free) begin
        ov_q <= 1'b1;
      end
      if (state_q == ST_SMO) begin
        sd_q[tap_sel] <= avg;
      end
      if ((state_q == ST_WR) && we_q) begin
        wi_q <= wi_q - 1'b1;
      end
      if ((state_q == ST_TGT) && rev_q) begin
        rp_q   <= jump ? wi_q : rp1;
        dist_q <= jump ? '0 : {1'b0, rp1 - wi_q};
      end
      if ((state_q == ST_DAT) && !op_q) begin
        h_q[0] <= ring_rdata;
        h_q[1] <= h_q[0];
        h_q[2] <= h_q[1];
        h_q[3] <= h_q[2];
        f_q[0] <= fr_q;
        f_q[1] <= f_q[0];
        f_q[2] <= f_q[1];
        f_q[3] <= f_q[2];
      end
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_q  <= in_i.operation;
          smp_q <= in_i.in_sample;
          req_q <= in_i.delay_request;
          tap_q <= in_i.tap_index;
          we_q  <= in_i.write_enable;
          rev_q <= in_i.reverse_mode;
        end
      end
      ST_SMB:  acc1_q <= prod[56:0];
      ST_SMO: begin
        dly_q <= dly_sm;
        fr_q  <= tc[15:8];
      end
      ST_SIM:  dly_q <= dly_si;
      ST_TGT:  ptr_q <= rev_q ? (jump ? wi_q : rp1) : tgt;
      ST_DAT: begin
        // Position is the sum of the two middle fractions after this shift.
        y_q <= ring_rdata;
        x_q <= {1'b0, f_q[0]} + {1'b0, f_q[1]};
      end
      ST_Q:    p_q  <= prod[PQR_W-1:0];
      ST_R:    q_q  <= prod[PQR_W-1:0];
      ST_N0:   r_q  <= prod[PQR_W-1:0];
      ST_N3:   n0_q <= -prod[31:0];
      ST_N1:   n3_q <= prod[31:0];
      ST_N2:   n1_q <= prod[31:0];
      ST_D1: begin
        n2_q <= -prod[31:0];
        c1_q <= n1_q[31] ? -$signed(g1[COEF_W-1:0]) : $signed(g1[COEF_W-1:0]);
      end
      ST_D3: begin
        c0_q <= n0_q[31] ? -$signed(q3) : $signed(q3);
        c2_q <= n2_q[31] ? -$signed(g2[COEF_W-1:0]) : $signed(g2[COEF_W-1:0]);
      end
      ST_M0:   c3_q  <= n3_q[31] ? -$signed(q3) : $signed(q3);
      ST_M1:   acc_q <= prod[ACC_W-1:0];
      ST_M2:   acc_q <= acc_f;
      ST_M3:   acc_q <= acc_f;
      ST_SUM:  y_q   <= y_sat;
      ST_OUT: begin
        if (out_free) begin
          os_q <= y_q;
          od_q <= dist_q;
        end
      end
      default: ;
    endcase
  end

  // Beats are refused while the ring clear sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ring_busy |-> !in_i.ready)
    else $error("input accepted during ring clear");

  // The sequencer never writes and reads the ring in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(ring_req.you_we && ring_req.re))
    else $error("ring write and read overlap");

  // A new result appears only when the sequencer leaves its final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(ov_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside final state");

endmodule
`default_nettype wire
